>>> rtl/kdlp_pkg.sv
// Shared constants for the three-key debouncer with long-press detection.
`default_nettype none

package kdlp_pkg;

    // Number of key slots on the ports and number of keys actually served.
    localparam int KEY_SLOTS = 3;
    localparam int KEY_COUNT = 3;

    // Field widths.
    localparam int DB_W   = 8;
    localparam int LONG_W = 16;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 16;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_KEY0_DEBOUNCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY1_DEBOUNCE = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY2_DEBOUNCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY0_LONG     = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY1_LONG     = 3'd4;
    localparam logic [IDX_W-1:0] REG_KEY2_LONG     = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [DB_W-1:0]   DB_RESET        = 8'd10;
    localparam logic [LONG_W-1:0] KEY0_LONG_RESET = 16'd12000;
    localparam logic [LONG_W-1:0] KEY1_LONG_RESET = 16'd100;
    localparam logic [LONG_W-1:0] KEY2_LONG_RESET = 16'd100;

endpackage

`default_nettype wire

>>> rtl/key_debounce_long_press.sv
// Top level of the three-key debouncer with press, release and long-press events.
//
// Usage: each request on the input channel (in_valid/in_ready) carries one
// tick of raw active-low key levels in raw_levels. Every request produces
// exactly one result on the output channel (out_valid/out_ready) carrying
// press, release and long-press event bits and the debounced levels.
// The request is captured in an input register; once the result register is
// free or being taken, the per-key integrators, hold timers and flags are
// updated and the result register is loaded. Throughput is one request per
// cycle while the receiver takes each result: the input register refills in
// the same cycle that it hands its request to the result register, and the
// result register is reloaded in the cycle its contents are taken.
// When the receiver stalls, the result register holds; the input register
// keeps one more request and then in_ready drops until the result is taken.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and takes effect at once; indexes above five are ignored.
// Reset clears all key state and both pipeline valid flags, and loads the
// debounce limits with 10 and the long-press times with 12000, 100, 100.
`default_nettype none

module key_debounce_long_press
    import kdlp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [KEY_SLOTS-1:0] raw_levels,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KEY_SLOTS-1:0]      press_events,
    output logic [KEY_SLOTS-1:0]      release_events,
    output logic [KEY_SLOTS-1:0]      long_press_events,
    output logic [KEY_SLOTS-1:0]      debounced_levels,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [DB_W-1:0]   db_limit_reg   [KEY_SLOTS];
    logic [LONG_W-1:0] long_limit_reg [KEY_SLOTS];

    // Per-key state.
    logic [DB_W-1:0]      integ_reg [KEY_SLOTS];
    logic [DB_W-1:0]      integ_next [KEY_SLOTS];
    logic [LONG_W-1:0]    hold_reg  [KEY_SLOTS];
    logic [LONG_W-1:0]    hold_next [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] pressed_reg;
    logic [KEY_SLOTS-1:0] pressed_next;
    logic [KEY_SLOTS-1:0] fired_reg;
    logic [KEY_SLOTS-1:0] fired_next;

    // Pipeline registers.
    logic                 in_valid_reg;
    logic [KEY_SLOTS-1:0] raw_reg;
    logic                 out_valid_reg;
    logic [KEY_SLOTS-1:0] press_reg;
    logic [KEY_SLOTS-1:0] press_next;
    logic [KEY_SLOTS-1:0] release_reg;
    logic [KEY_SLOTS-1:0] release_next;
    logic [KEY_SLOTS-1:0] long_reg;
    logic [KEY_SLOTS-1:0] long_next;

    logic advance;

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid         = out_valid_reg;
    assign press_events      = press_reg;
    assign release_events    = release_reg;
    assign long_press_events = long_reg;
    assign debounced_levels  = pressed_reg;

    // Per-key update of integrator, hold timer and flags for one tick.
    always_comb
    begin
        logic              down;
        logic              rise;
        logic              fall;
        logic              fired_mid;
        logic [LONG_W-1:0] hold_mid;

        press_next   = '0;
        release_next = '0;
        long_next    = '0;
        pressed_next = pressed_reg;
        fired_next   = fired_reg;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            integ_next[k] = integ_reg[k];
            hold_next[k]  = hold_reg[k];
        end

        for (int k = 0; k < KEY_COUNT; k++)
        begin
            down = !raw_reg[k];
            rise = 1'b0;
            fall = 1'b0;

            // The hold timer counts down first; expiry fires a long press.
            hold_mid  = hold_reg[k];
            fired_mid = fired_reg[k];
            if (hold_reg[k] != '0)
            begin
                hold_mid = hold_reg[k] - LONG_W'(1);
                if (hold_reg[k] == LONG_W'(1))
                begin
                    long_next[k] = 1'b1;
                    fired_mid    = 1'b1;
                end
            end

            // Saturating integrator; a zero limit passes the level straight through.
            if (db_limit_reg[k] == '0)
            begin
                integ_next[k] = '0;
                rise          = down;
                fall          = !down;
            end
            else if (down)
            begin
                if (integ_reg[k] < db_limit_reg[k])
                begin
                    integ_next[k] = integ_reg[k] + DB_W'(1);
                    rise          = (integ_reg[k] + DB_W'(1)) == db_limit_reg[k];
                end
            end
            else
            begin
                if (integ_reg[k] != '0)
                begin
                    integ_next[k] = integ_reg[k] - DB_W'(1);
                    fall          = integ_reg[k] == DB_W'(1);
                end
            end

            // Debounced edges raise events and manage the hold timer.
            hold_next[k]  = hold_mid;
            fired_next[k] = fired_mid;
            if (rise)
            begin
                if (!pressed_reg[k])
                begin
                    if (long_limit_reg[k] != '0)
                    begin
                        hold_next[k] = long_limit_reg[k];
                    end
                    press_next[k] = 1'b1;
                end
                pressed_next[k] = 1'b1;
            end
            if (fall)
            begin
                if (pressed_reg[k])
                begin
                    if (fired_mid)
                    begin
                        fired_next[k] = 1'b0;
                    end
                    else
                    begin
                        release_next[k] = 1'b1;
                    end
                    hold_next[k] = '0;
                end
                pressed_next[k] = 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                db_limit_reg[k] <= DB_RESET;
            end
            long_limit_reg[0] <= KEY0_LONG_RESET;
            long_limit_reg[1] <= KEY1_LONG_RESET;
            long_limit_reg[2] <= KEY2_LONG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY0_DEBOUNCE: db_limit_reg[0]   <= cfg_data[DB_W-1:0];
                REG_KEY1_DEBOUNCE: db_limit_reg[1]   <= cfg_data[DB_W-1:0];
                REG_KEY2_DEBOUNCE: db_limit_reg[2]   <= cfg_data[DB_W-1:0];
                REG_KEY0_LONG:     long_limit_reg[0] <= cfg_data;
                REG_KEY1_LONG:     long_limit_reg[1] <= cfg_data;
                REG_KEY2_LONG:     long_limit_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Key state and pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                integ_reg[k] <= '0;
                hold_reg[k]  <= '0;
            end
            pressed_reg   <= '0;
            fired_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                for (int k = 0; k < KEY_SLOTS; k++)
                begin
                    integ_reg[k] <= integ_next[k];
                    hold_reg[k]  <= hold_next[k];
                end
                pressed_reg   <= pressed_next;
                fired_reg     <= fired_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            raw_reg <= raw_levels;
        end
        if (advance)
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            long_reg    <= long_next;
        end
    end

endmodule

`default_nettype wire
